// File: sv/mzx_pkg.sv
// mzx_pkg: shared types and constants for the maze explorer core.
// No dependencies.
`timescale 1ns / 1ps
package mzx_pkg;
   localparam int HistDepth = 128;
   localparam int PathDepth = 256;
   localparam int HistAw = $clog2(HistDepth);
   localparam int PathAw = $clog2(PathDepth);
   localparam int HistCw = $clog2(HistDepth + 1);
   localparam int PathCw = $clog2(PathDepth + 1);

   localparam logic [1:0] TURN_S = 2'd0;
   localparam logic [1:0] TURN_R = 2'd1;
   localparam logic [1:0] TURN_B = 2'd2;
   localparam logic [1:0] TURN_L = 2'd3;

   localparam logic [1:0] REG_SIDE = 2'd0;
   localparam logic [1:0] REG_STRAIGHT = 2'd1;
   localparam logic [1:0] REG_GOAL = 2'd2;

   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_READ = 1'b1;

   // one history record travelling down the cell chain
   typedef struct packed {
      logic       valid;
      logic [1:0] heading;
      logic [7:0] north;
      logic [7:0] east;
   } hist_rec_type;

   typedef struct packed {
      logic       shift;
      logic       load;
      logic       clear_hits;
      logic [1:0] heading;
      logic [7:0] north;
      logic [7:0] east;
   } hist_ctl_type;

   function automatic logic [7:0] sat_step(input logic [7:0] v, input logic up);
      logic [7:0] r;
      r = v;
      if (up && v != 8'h7f) r = v + 8'd1;
      if (!up && v != 8'h80) r = v - 8'd1;
      return r;
   endfunction
endpackage

// File: sv/maze_explorer_with_path_reduction_core.sv
// maze_explorer_with_path_reduction_core: top level, event sequencer + path store.
// Depends on mzx_pkg, mzx_hist_chain, mzx_ram.
// Sequence, start to rsp_valid: goal and ignored events go straight to done, reads wait on
// the RAM, moves turn, compare, push, then check the path when it holds 3 or more and fold it on a back turn.
// Throughput: one transaction at a time; busy high until the rsp_valid cycle.
// Reset: synchronous; sets position, heading, thresholds to defaults, clears counts, history valid bits.
`timescale 1ns / 1ps
module maze_explorer_with_path_reduction_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [9:0]  req_outer_left,
   input  logic [9:0]  req_inner_left,
   input  logic [9:0]  req_center_sensor,
   input  logic [9:0]  req_inner_right,
   input  logic [9:0]  req_outer_right,
   input  logic [7:0]  req_path_index,
   output logic        rsp_valid,
   output logic [1:0]  rsp_turn_code,
   output logic        rsp_goal_reached,
   output logic        rsp_ignored,
   output logic [1:0]  rsp_heading,
   output logic signed [7:0] rsp_north_pos,
   output logic signed [7:0] rsp_east_pos,
   output logic        rsp_right_hand_mode,
   output logic [8:0]  rsp_stored_length,
   output logic        rsp_path_full,
   output logic [1:0]  rsp_path_entry,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_READ_W, S_MOVE, S_CMP, S_PUSH, S_RD1, S_RD2, S_RD2_W,
      S_FOLD, S_DONE
   } state_type;

   state_type state_ff;
   logic [9:0] side_ff, straight_ff, goal_ff;
   logic [1:0] heading_ff, turn_ff, entry_ff, t1_ff;
   logic [7:0] north_ff, east_ff;
   logic [mzx_pkg::HistCw-1:0] hcount_ff;
   logic [mzx_pkg::PathCw-1:0] tcount_ff;
   logic rh_ff, finished_ff, ign_ff, full_ff;
   logic [mzx_pkg::PathAw-1:0] idx_ff;
   logic op_ff;
   logic [9:0] ol_ff, il_ff, cs_ff, ir_ff, or_ff;

   logic ram_we;
   logic [mzx_pkg::PathAw-1:0] ram_addr;
   logic [1:0] ram_wdata, ram_rdata;
   mzx_pkg::hist_ctl_type hctl;
   logic odd_hits;

   mzx_ram #(.Width(2), .Depth(mzx_pkg::PathDepth)) u_path (
      .clock, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
   );
   mzx_hist_chain u_hist (.clock, .reset, .ctl(hctl), .odd_hits);

   assign pready = 1'b1;
   assign busy = state_ff != S_IDLE;
   always_comb begin
      unique case (paddr[3:2])
         mzx_pkg::REG_SIDE:     prdata = {22'd0, side_ff};
         mzx_pkg::REG_STRAIGHT: prdata = {22'd0, straight_ff};
         mzx_pkg::REG_GOAL:     prdata = {22'd0, goal_ff};
         default:               prdata = 32'd0;
      endcase
   end

   always_comb begin
      hctl.shift = state_ff == S_PUSH && hcount_ff < mzx_pkg::HistCw'(mzx_pkg::HistDepth);
      hctl.load = 1'b0;
      hctl.clear_hits = 1'b0;
      hctl.heading = heading_ff;
      hctl.north = north_ff;
      hctl.east = east_ff;
      ram_we = 1'b0;
      ram_addr = idx_ff;
      ram_wdata = turn_ff;
      unique case (state_ff)
         S_PUSH: begin
            ram_we = tcount_ff < mzx_pkg::PathCw'(mzx_pkg::PathDepth);
            ram_addr = tcount_ff[mzx_pkg::PathAw-1:0];
         end
         S_RD1: ram_addr = tcount_ff[mzx_pkg::PathAw-1:0] - mzx_pkg::PathAw'(2);
         S_RD2: ram_addr = tcount_ff[mzx_pkg::PathAw-1:0] - mzx_pkg::PathAw'(3);
         S_FOLD: begin
            ram_we = 1'b1;
            ram_addr = tcount_ff[mzx_pkg::PathAw-1:0] - mzx_pkg::PathAw'(3);
            ram_wdata = turn_ff + mzx_pkg::TURN_B + t1_ff;
         end
         default: ;
      endcase
   end

   logic lft, rgt, str;
   logic [1:0] choice;
   assign lft = ol_ff > side_ff;
   assign rgt = or_ff > side_ff;
   assign str = il_ff > straight_ff || cs_ff > straight_ff || ir_ff > straight_ff;
   always_comb begin
      if (rh_ff) choice = rgt ? mzx_pkg::TURN_R : str ? mzx_pkg::TURN_S :
                          lft ? mzx_pkg::TURN_L : mzx_pkg::TURN_B;
      else choice = lft ? mzx_pkg::TURN_L : str ? mzx_pkg::TURN_S :
                    rgt ? mzx_pkg::TURN_R : mzx_pkg::TURN_B;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         side_ff <= 10'd100;
         straight_ff <= 10'd200;
         goal_ff <= 10'd600;
         heading_ff <= 2'd1;
         north_ff <= 8'd1;
         east_ff <= 8'd0;
         hcount_ff <= '0;
         tcount_ff <= '0;
         rh_ff <= 1'b0;
         finished_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
               mzx_pkg::REG_SIDE:     side_ff <= pwdata[9:0];
               mzx_pkg::REG_STRAIGHT: straight_ff <= pwdata[9:0];
               mzx_pkg::REG_GOAL:     goal_ff <= pwdata[9:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: if (start) begin
               op_ff <= req_operation;
               ol_ff <= req_outer_left;
               il_ff <= req_inner_left;
               cs_ff <= req_center_sensor;
               ir_ff <= req_inner_right;
               or_ff <= req_outer_right;
               idx_ff <= req_path_index[mzx_pkg::PathAw-1:0];
               turn_ff <= mzx_pkg::TURN_S;
               ign_ff <= 1'b0;
               full_ff <= 1'b0;
               entry_ff <= 2'd0;
               state_ff <= req_operation == mzx_pkg::OP_READ ? S_READ : S_MOVE;
            end
            S_READ: state_ff <= S_READ_W;
            S_READ_W: begin
               if ({1'b0, idx_ff} < tcount_ff) entry_ff <= ram_rdata;
               state_ff <= S_DONE;
            end
            S_MOVE: begin
               if (finished_ff) begin
                  ign_ff <= 1'b1;
                  state_ff <= S_DONE;
               end else if (il_ff > goal_ff && cs_ff > goal_ff && ir_ff > goal_ff) begin
                  finished_ff <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  turn_ff <= choice;
                  heading_ff <= heading_ff - choice;
                  unique case (2'(heading_ff - choice))
                     2'd0: east_ff <= mzx_pkg::sat_step(east_ff, 1'b1);
                     2'd1: north_ff <= mzx_pkg::sat_step(north_ff, 1'b1);
                     2'd2: east_ff <= mzx_pkg::sat_step(east_ff, 1'b0);
                     default: north_ff <= mzx_pkg::sat_step(north_ff, 1'b0);
                  endcase
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               rh_ff <= odd_hits;
               state_ff <= S_PUSH;
            end
            S_PUSH: begin
               if (hcount_ff < mzx_pkg::HistCw'(mzx_pkg::HistDepth))
                  hcount_ff <= hcount_ff + 1'b1;
               if (tcount_ff < mzx_pkg::PathCw'(mzx_pkg::PathDepth)) begin
                  tcount_ff <= tcount_ff + 1'b1;
                  state_ff <= S_RD1;
               end else begin
                  full_ff <= 1'b1;
                  state_ff <= S_DONE;
               end
            end
            S_RD1: state_ff <= tcount_ff < mzx_pkg::PathCw'(3) ? S_DONE : S_RD2;
            S_RD2: state_ff <= S_RD2_W;
            S_RD2_W: begin
               // t1_ff holds the entry before the newest one
               if (t1_ff == mzx_pkg::TURN_B) begin
                  state_ff <= S_FOLD;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_FOLD: begin
               tcount_ff <= tcount_ff - mzx_pkg::PathCw'(2);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_valid <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_turn_code = turn_ff;
   assign rsp_goal_reached = finished_ff;
   assign rsp_ignored = ign_ff;
   assign rsp_heading = heading_ff;
   assign rsp_north_pos = north_ff;
   assign rsp_east_pos = east_ff;
   assign rsp_right_hand_mode = rh_ff;
   assign rsp_stored_length = 9'(tcount_ff);
   assign rsp_path_full = full_ff;
   assign rsp_path_entry = entry_ff;
   logic unused;
   assign unused = op_ff ^ hctl.load ^ hctl.clear_hits;
   always_ff @(posedge clock) t1_ff <= ram_rdata;
endmodule

// File: sv/mzx_ram.sv
// mzx_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mzx_ram #(
   parameter int Width = 2,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// File: sv/mzx_hist_cell.sv
// mzx_hist_cell: one history cell; holds a record, passes it on, compares it.
// Depends on mzx_pkg.
`timescale 1ns / 1ps
module mzx_hist_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mzx_pkg::hist_ctl_type ctl,
   input  mzx_pkg::hist_rec_type rec_prev,
   output mzx_pkg::hist_rec_type rec_out,
   input  logic                  parity_prev,
   output logic                  parity_out
);
   mzx_pkg::hist_rec_type rec_ff;
   logic match;
   assign match = rec_ff.valid && rec_ff.heading == ctl.heading
                  && rec_ff.north == ctl.north && rec_ff.east == ctl.east;
   assign rec_out = rec_ff;
   assign parity_out = parity_prev ^ match;
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.valid <= 1'b0;
      end else if (ctl.shift) begin
         rec_ff <= rec_prev;
      end
   end
endmodule

// File: sv/mzx_hist_chain.sv
// mzx_hist_chain: row of history cells; new records enter cell 0 and shift.
// Depends on mzx_pkg, mzx_hist_cell.
`timescale 1ns / 1ps
module mzx_hist_chain (
   input  logic                  clock,
   input  logic                  reset,
   input  mzx_pkg::hist_ctl_type ctl,
   output logic                  odd_hits
);
   mzx_pkg::hist_rec_type recs [mzx_pkg::HistDepth+1];
   logic par [mzx_pkg::HistDepth+1];
   assign recs[0] = '{valid: 1'b1, heading: ctl.heading, north: ctl.north,
                      east: ctl.east};
   assign par[0] = 1'b0;
   for (genvar g = 0; g < mzx_pkg::HistDepth; g++) begin : g_cell
      mzx_hist_cell u_cell (
         .clock, .reset, .ctl,
         .rec_prev(recs[g]), .rec_out(recs[g+1]),
         .parity_prev(par[g]), .parity_out(par[g+1])
      );
   end
   assign odd_hits = par[mzx_pkg::HistDepth];
endmodule

// File: sv/mzx_checker.sv
// mzx_checker: port-level assertions for the maze explorer core, and bind.
// Depends on maze_explorer_with_path_reduction_core.
`timescale 1ns / 1ps
module mzx_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_ignored,
   input logic       rsp_goal_reached,
   input logic [1:0] rsp_turn_code,
   input logic [8:0] rsp_stored_length
);
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted start did not raise busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_ign_goal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ignored |-> rsp_goal_reached && rsp_turn_code == 2'd0)
      else $error("ignored event without goal");
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_stored_length <= 9'd256) else $error("length overflow");
endmodule

bind maze_explorer_with_path_reduction_core mzx_checker u_mzx_checker (.*);
